FILE: rtl/fwess_pkg.sv
// Shared types, opcodes and the direction table of the four-wheel speed sync block.
package fwess_pkg;

  localparam int NUM_WHEELS = 4;

  localparam logic [2:0] OP_ENCODER      = 3'd0;
  localparam logic [2:0] OP_SYNC         = 3'd1;
  localparam logic [2:0] OP_MOVE         = 3'd2;
  localparam logic [2:0] OP_STOP         = 3'd3;
  localparam logic [2:0] OP_RESET_COUNTS = 3'd4;

  localparam logic [2:0] DIR_FWD  = 3'd0;
  localparam logic [2:0] DIR_BACK = 3'd1;
  localparam logic [2:0] DIR_LEFT = 3'd2;
  localparam logic [2:0] DIR_RIGHT = 3'd3;
  localparam logic [2:0] DIR_CW   = 3'd4;
  localparam logic [2:0] DIR_CCW  = 3'd5;

  localparam logic [15:0] SYNC_DELAY_RESET = 16'd100;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [1:0]  wheel;
    logic        level_a;
    logic        level_b;
    logic [31:0] time_us;
    logic [31:0] time_ms;
    logic [2:0]  direction;
    logic [7:0]  duty;
  } item_t;

  typedef struct packed {
    logic ld_sum;
    logic ld_out;
  } pipe_ctrl_t;

  // Drive pattern per direction; bit 2k is forward and bit 2k+1 backward for wheel k.
  function automatic logic [7:0] dir_pattern(input logic [2:0] dir);
    logic [7:0] bits;
    case (dir)
      DIR_FWD:   bits = 8'h55;
      DIR_BACK:  bits = 8'hAA;
      DIR_LEFT:  bits = 8'h96;
      DIR_RIGHT: bits = 8'h69;
      DIR_CW:    bits = 8'h99;
      DIR_CCW:   bits = 8'h66;
      default:   bits = 8'h00;
    endcase
    return bits;
  endfunction

  function automatic logic dir_known(input logic [2:0] dir);
    logic ok;
    case (dir)
      DIR_FWD, DIR_BACK, DIR_LEFT, DIR_RIGHT, DIR_CW, DIR_CCW: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

FILE: rtl/fwess_core.sv
// Wheel state and its update: encoder counting, move, stop, count reset and duty trimming.
module fwess_core #(
  parameter int COUNT_WIDTH = 32,
  parameter int DUTY_MAX = 255,
  localparam int DutyW = ($clog2(DUTY_MAX + 1) > 8) ? $clog2(DUTY_MAX + 1) : 8
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               cfg_we_i,
  input  logic [15:0]                                        cfg_wdata_i,
  input  logic                                               upd_en_i,
  input  fwess_pkg::item_t                                   item_i,
  output logic [fwess_pkg::NUM_WHEELS-1:0][COUNT_WIDTH-1:0] counts_o,
  output logic [fwess_pkg::NUM_WHEELS-1:0][DutyW-1:0]       duties_o,
  output logic [fwess_pkg::NUM_WHEELS-1:0][31:0]            periods_o,
  output logic [7:0]                                         drive_o
);
  import fwess_pkg::*;

  localparam logic [DutyW-1:0] DutyMaxV = DutyW'(DUTY_MAX);

  logic [NUM_WHEELS-1:0][COUNT_WIDTH-1:0] counts_q, counts_d;
  logic [NUM_WHEELS-1:0]                  last_a_q, last_a_d;
  logic [NUM_WHEELS-1:0][31:0]            last_time_q, last_time_d;
  logic [NUM_WHEELS-1:0][31:0]            periods_q, periods_d;
  logic [NUM_WHEELS-1:0][DutyW-1:0]       duties_q, duties_d;
  logic [7:0]                             drive_q, drive_d;
  logic [31:0]                            move_start_q, move_start_d;
  logic [15:0]                            sync_delay_q;

  logic [31:0] elapsed;
  logic        sync_due;

  // One trim step toward the front-left interval, saturated to the duty range.
  function automatic logic [DutyW-1:0] trim_duty(input logic [DutyW-1:0] d,
                                                 input logic [31:0] p,
                                                 input logic [31:0] ref_period);
    logic [DutyW-1:0] t;
    if (p > ref_period) begin
      t = (d < DutyMaxV) ? d + DutyW'(1) : DutyMaxV;
    end else if (p < ref_period) begin
      t = (d != '0) ? d - DutyW'(1) : d;
      t = (t > DutyMaxV) ? DutyMaxV : t;
    end else begin
      t = (d > DutyMaxV) ? DutyMaxV : d;
    end
    return t;
  endfunction

  assign elapsed  = item_i.time_ms - move_start_q;
  assign sync_due = elapsed > {16'd0, sync_delay_q};

  always_comb begin
    counts_d     = counts_q;
    last_a_d     = last_a_q;
    last_time_d  = last_time_q;
    periods_d    = periods_q;
    duties_d     = duties_q;
    drive_d      = drive_q;
    move_start_d = move_start_q;
    if (upd_en_i) begin
      case (item_i.opcode)
        OP_ENCODER: begin
          periods_d[item_i.wheel]   = item_i.time_us - last_time_q[item_i.wheel];
          last_time_d[item_i.wheel] = item_i.time_us;
          last_a_d[item_i.wheel]    = item_i.level_a;
          // x2 decoding: only a change on channel A moves the count.
          if (item_i.level_a != last_a_q[item_i.wheel]) begin
            if (item_i.level_a != item_i.level_b) begin
              counts_d[item_i.wheel] = counts_q[item_i.wheel] + COUNT_WIDTH'(1);
            end else begin
              counts_d[item_i.wheel] = counts_q[item_i.wheel] - COUNT_WIDTH'(1);
            end
          end
        end
        OP_SYNC: begin
          if (sync_due) begin
            for (int i = 1; i < NUM_WHEELS; i++) begin
              duties_d[i] = trim_duty(duties_q[i], periods_q[i], periods_q[0]);
            end
          end
        end
        OP_MOVE: begin
          if (dir_known(item_i.direction)) begin
            drive_d = dir_pattern(item_i.direction);
          end
          for (int i = 0; i < NUM_WHEELS; i++) begin
            duties_d[i] = DutyW'(item_i.duty);
          end
          move_start_d = item_i.time_ms;
        end
        OP_STOP: begin
          drive_d  = '0;
          duties_d = '0;
        end
        OP_RESET_COUNTS: begin
          counts_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counts_q     <= '0;
      last_a_q     <= '0;
      last_time_q  <= '0;
      periods_q    <= '0;
      duties_q     <= '0;
      drive_q      <= '0;
      move_start_q <= '0;
      sync_delay_q <= SYNC_DELAY_RESET;
    end else begin
      counts_q     <= counts_d;
      last_a_q     <= last_a_d;
      last_time_q  <= last_time_d;
      periods_q    <= periods_d;
      duties_q     <= duties_d;
      drive_q      <= drive_d;
      move_start_q <= move_start_d;
      if (cfg_we_i) begin
        sync_delay_q <= cfg_wdata_i;
      end
    end
  end

  assign counts_o  = counts_q;
  assign duties_o  = duties_q;
  assign periods_o = periods_q;
  assign drive_o   = drive_q;

endmodule

FILE: rtl/fwess_avg.sv
// Two-stage averaging of the four wheel counts: pair sums, then total and divide by four.
module fwess_avg #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                               clk_i,
  input  fwess_pkg::pipe_ctrl_t                              ctrl_i,
  input  logic [fwess_pkg::NUM_WHEELS-1:0][COUNT_WIDTH-1:0] counts_i,
  output logic [31:0]                                        avg_o,
  output logic [31:0]                                        abs_avg_o
);
  import fwess_pkg::*;

  localparam int PairW = COUNT_WIDTH + 1;
  localparam int TotW  = COUNT_WIDTH + 2;
  localparam int ExtW  = (TotW > 32) ? TotW : 32;

  logic [NUM_WHEELS-1:0][COUNT_WIDTH-1:0] mag;
  logic signed [PairW-1:0] sum_lo_d, sum_hi_d, sum_lo_q, sum_hi_q;
  logic [PairW-1:0]        abs_lo_d, abs_hi_d, abs_lo_q, abs_hi_q;
  logic signed [TotW-1:0]  total, floor_q4;
  logic [TotW-1:0]         quot, abs_total;
  logic                    round_up;
  logic signed [ExtW-1:0]  avg_ext;
  logic [ExtW-1:0]         abs_ext;
  logic [31:0]             avg_q, abs_q;

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      // The most negative count maps to its exact magnitude as an unsigned value.
      mag[i] = counts_i[i][COUNT_WIDTH-1] ? (~counts_i[i] + COUNT_WIDTH'(1)) : counts_i[i];
    end
    sum_lo_d = PairW'($signed(counts_i[0])) + PairW'($signed(counts_i[1]));
    sum_hi_d = PairW'($signed(counts_i[2])) + PairW'($signed(counts_i[3]));
    abs_lo_d = PairW'(mag[0]) + PairW'(mag[1]);
    abs_hi_d = PairW'(mag[2]) + PairW'(mag[3]);
  end

  always_comb begin
    total     = TotW'(sum_lo_q) + TotW'(sum_hi_q);
    floor_q4  = total >>> 2;
    // Arithmetic shift rounds down; a negative total with a remainder steps back toward zero.
    round_up  = total[TotW-1] && (total[1:0] != 2'b00);
    quot      = TotW'(floor_q4) + TotW'(round_up);
    avg_ext   = ExtW'($signed(quot));
    abs_total = TotW'(abs_lo_q) + TotW'(abs_hi_q);
    abs_ext   = ExtW'(abs_total >> 2);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_sum) begin
      sum_lo_q <= sum_lo_d;
      sum_hi_q <= sum_hi_d;
      abs_lo_q <= abs_lo_d;
      abs_hi_q <= abs_hi_d;
    end
    if (ctrl_i.ld_out) begin
      avg_q <= avg_ext[31:0];
      abs_q <= abs_ext[31:0];
    end
  end

  assign avg_o     = avg_q;
  assign abs_avg_o = abs_q;

endmodule

FILE: rtl/four_wheel_encoder_speed_sync.sv
// Top level of the four-wheel encoder counter and speed sync block.
//
//  Channel   Signals                          Width  Direction  Contents
//  input     s_axis_tvalid/tready/tdata       88     in         one command or encoder event
//  result    m_axis_tvalid/tready/tdata       168    out        duties, drive bits, counts
//  config    cfg_we_i/cfg_wdata_i             16     in         sync_delay_ms
//
// One transaction is accepted per cycle unless the pipeline is full and the result is stalled;
// it then passes the stages in turn: the input register, the state update, the pair sums and
// the output register. Each stage holds its contents when the next one is full and held, so a
// stalled result only blocks input once all four stages are occupied.
// Reset clears all wheel state and sets the sync delay to 100 ms; no clearing pass is needed.
module four_wheel_encoder_speed_sync #(
  parameter int COUNT_WIDTH = 32,
  parameter int DUTY_MAX = 255
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode[2:0], wheel[4:3], level_a[5], level_b[6], time_us[38:7], time_ms[70:39],
  // direction[73:71], duty[81:74], zero fill[87:82]
  input  logic [87:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // duty_front_left[7:0], duty_front_right[15:8], duty_back_left[23:16],
  // duty_back_right[31:24], drive_bits[39:32], wheel_count[71:40],
  // wheel_period[103:72], average_count[135:104], average_abs_count[167:136]
  output logic [167:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i
);
  import fwess_pkg::*;

  localparam int DutyW = ($clog2(DUTY_MAX + 1) > 8) ? $clog2(DUTY_MAX + 1) : 8;
  localparam int ExtW  = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  logic a_v_q, b_v_q, c_v_q, d_v_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d;
  logic upd_en;

  item_t item_d, item_q;
  logic [1:0] wheel_b_q;

  logic [NUM_WHEELS-1:0][COUNT_WIDTH-1:0] counts;
  logic [NUM_WHEELS-1:0][DutyW-1:0]       duties;
  logic [NUM_WHEELS-1:0][31:0]            periods;
  logic [7:0]                             drive;

  logic signed [ExtW-1:0] wcount_ext;
  logic [NUM_WHEELS-1:0][7:0] duty_c_q, duty_d_q;
  logic [7:0]  drive_c_q, drive_d_q;
  logic [31:0] wcount_c_q, wcount_d_q;
  logic [31:0] period_c_q, period_d_q;
  logic [31:0] avg, abs_avg;
  pipe_ctrl_t  avg_ctrl;

  assign rdy_d = !d_v_q || m_axis_tready;
  assign rdy_c = !c_v_q || rdy_d;
  assign rdy_b = !b_v_q || rdy_c;
  assign rdy_a = !a_v_q || rdy_b;

  assign s_axis_tready = rdy_a;
  assign m_axis_tvalid = d_v_q;

  // The wheel state changes only when the item moves into the update stage, so the state
  // stays equal to that stage's snapshot for as long as it is held there.
  assign upd_en = a_v_q && rdy_b;

  always_comb begin
    item_d.opcode    = s_axis_tdata[2:0];
    item_d.wheel     = s_axis_tdata[4:3];
    item_d.level_a   = s_axis_tdata[5];
    item_d.level_b   = s_axis_tdata[6];
    item_d.time_us   = s_axis_tdata[38:7];
    item_d.time_ms   = s_axis_tdata[70:39];
    item_d.direction = s_axis_tdata[73:71];
    item_d.duty      = s_axis_tdata[81:74];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        a_v_q <= s_axis_tvalid;
      end
      if (rdy_b) begin
        b_v_q <= a_v_q;
      end
      if (rdy_c) begin
        c_v_q <= b_v_q;
      end
      if (rdy_d) begin
        d_v_q <= c_v_q;
      end
    end
  end

  fwess_core #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .DUTY_MAX   (DUTY_MAX)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .upd_en_i   (upd_en),
    .item_i     (item_q),
    .counts_o   (counts),
    .duties_o   (duties),
    .periods_o  (periods),
    .drive_o    (drive)
  );

  assign wcount_ext = ExtW'($signed(counts[wheel_b_q]));

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      item_q <= item_d;
    end
    if (rdy_b) begin
      wheel_b_q <= item_q.wheel;
    end
    if (rdy_c) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        duty_c_q[i] <= duties[i][7:0];
      end
      drive_c_q  <= drive;
      wcount_c_q <= wcount_ext[31:0];
      period_c_q <= periods[wheel_b_q];
    end
    if (rdy_d) begin
      duty_d_q   <= duty_c_q;
      drive_d_q  <= drive_c_q;
      wcount_d_q <= wcount_c_q;
      period_d_q <= period_c_q;
    end
  end

  assign avg_ctrl.ld_sum = rdy_c;
  assign avg_ctrl.ld_out = rdy_d;

  fwess_avg #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_avg (
    .clk_i    (clk_i),
    .ctrl_i   (avg_ctrl),
    .counts_i (counts),
    .avg_o    (avg),
    .abs_avg_o(abs_avg)
  );

  assign m_axis_tdata[7:0]     = duty_d_q[0];
  assign m_axis_tdata[15:8]    = duty_d_q[1];
  assign m_axis_tdata[23:16]   = duty_d_q[2];
  assign m_axis_tdata[31:24]   = duty_d_q[3];
  assign m_axis_tdata[39:32]   = drive_d_q;
  assign m_axis_tdata[71:40]   = wcount_d_q;
  assign m_axis_tdata[103:72]  = period_d_q;
  assign m_axis_tdata[135:104] = avg;
  assign m_axis_tdata[167:136] = abs_avg;

  // Input may only stall when every stage holds a transaction.
  assert_full_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (a_v_q && b_v_q && c_v_q && d_v_q))
    else $error("input stalled with a free pipeline stage");

  // Transactions in flight change only by those accepted and delivered.
  assert_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones({a_v_q, b_v_q, c_v_q, d_v_q}) ==
              $past($countones({a_v_q, b_v_q, c_v_q, d_v_q}))
              + $past(int'(s_axis_tvalid && s_axis_tready))
              - $past(int'(m_axis_tvalid && m_axis_tready))))
    else $error("transaction lost or duplicated in the pipeline");

  assert_move_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_en && item_q.opcode == OP_MOVE) |=>
      (duties[0] == DutyW'($past(item_q.duty)) && duties[3] == DutyW'($past(item_q.duty))))
    else $error("move did not load the duties");

  assert_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_en && item_q.opcode == OP_STOP) |=> (drive == 8'h00 && duties == '0))
    else $error("stop did not clear drive bits and duties");

  assert_reset_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_en && item_q.opcode == OP_RESET_COUNTS) |=> (counts == '0))
    else $error("count reset left a nonzero count");

endmodule

FILE: sim/four_wheel_encoder_speed_sync_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the four-wheel encoder counter and speed sync block.
module four_wheel_encoder_speed_sync_test;
  import fwess_pkg::*;

  // Opcodes that the block must treat as no-ops, and directions that keep the drive bits.
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam logic [2:0] DIR_SPARE_6 = 3'd6;
  localparam logic [2:0] DIR_SPARE_7 = 3'd7;

  localparam int PIPE_DEPTH = 4;
  localparam int MAX_IDLE = 18;
  localparam int PHASE_ITEMS = 255;
  localparam logic [7:0] DUTY_CEIL = 8'd255;
  // Drive bits per known direction, direction 0 in the lowest byte.
  localparam logic [47:0] STEER_BITS = 48'h66_99_69_96_AA_55;

  // Result layout, last field first so that the struct maps straight onto tdata.
  typedef struct packed {
    logic [31:0] avg_abs;
    logic [31:0] avg;
    logic [31:0] period;
    logic [31:0] count;
    logic [7:0]  drive;
    logic [7:0]  duty_br;
    logic [7:0]  duty_bl;
    logic [7:0]  duty_fr;
    logic [7:0]  duty_fl;
  } status_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [87:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [167:0] m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [15:0]  cfg_wdata_i = '0;

  // Shadow state of the controller.
  logic [31:0] enc_count [NUM_WHEELS];
  logic        enc_last_a [NUM_WHEELS];
  logic [31:0] enc_last_us [NUM_WHEELS];
  logic [31:0] enc_period [NUM_WHEELS];
  logic [7:0]  wheel_duty [NUM_WHEELS];
  logic [7:0]  drive_state;
  logic [31:0] move_start;
  logic [15:0] trim_delay;

  status_t pending_status [$];
  status_t want_status;
  status_t got_status;
  int      cmds_taken = 0;
  int      status_done = 0;
  int      mismatches = 0;
  int      rx_mark = 0;
  int      rx_hold = 0;
  bit      quiet = 1'b0;

  four_wheel_encoder_speed_sync dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      enc_count[i] = '0;
      enc_last_a[i] = 1'b0;
      enc_last_us[i] = '0;
      enc_period[i] = '0;
      wheel_duty[i] = '0;
    end
    drive_state = '0;
    move_start = '0;
    trim_delay = SYNC_DELAY_RESET;
  end

  function automatic logic [87:0] to_tdata(input item_t c);
    return {6'd0, c.duty, c.direction, c.time_ms, c.time_us, c.level_b, c.level_a,
            c.wheel, c.opcode};
  endfunction

  // Updates the shadow state with one accepted command and returns the status it reports.
  function automatic status_t apply_command(input logic [87:0] d);
    logic [2:0]  op;
    logic [1:0]  w;
    logic        a;
    logic        b;
    logic [31:0] tus;
    logic [31:0] tms;
    logic [2:0]  dir;
    logic [7:0]  duty;
    logic [31:0] elapsed;
    longint      total;
    longint      abs_total;
    longint      v;
    status_t     s;
    op = d[2:0];
    w = d[4:3];
    a = d[5];
    b = d[6];
    tus = d[38:7];
    tms = d[70:39];
    dir = d[73:71];
    duty = d[81:74];
    case (op)
      OP_ENCODER: begin
        enc_period[w] = tus - enc_last_us[w];
        enc_last_us[w] = tus;
        if (a != enc_last_a[w]) begin
          enc_count[w] = (a != b) ? enc_count[w] + 32'd1 : enc_count[w] - 32'd1;
        end
        enc_last_a[w] = a;
      end
      OP_SYNC: begin
        elapsed = tms - move_start;
        if (elapsed > {16'd0, trim_delay}) begin
          // The front left wheel is the speed reference for the other three.
          for (int i = 1; i < NUM_WHEELS; i++) begin
            if (enc_period[i] > enc_period[0] && wheel_duty[i] != DUTY_CEIL) begin
              wheel_duty[i] = wheel_duty[i] + 8'd1;
            end else if (enc_period[i] < enc_period[0] && wheel_duty[i] != 8'd0) begin
              wheel_duty[i] = wheel_duty[i] - 8'd1;
            end
          end
        end
      end
      OP_MOVE: begin
        if (dir <= DIR_CCW) drive_state = STEER_BITS[dir * 8 +: 8];
        for (int i = 0; i < NUM_WHEELS; i++) wheel_duty[i] = duty;
        move_start = tms;
      end
      OP_STOP: begin
        drive_state = '0;
        for (int i = 0; i < NUM_WHEELS; i++) wheel_duty[i] = '0;
      end
      OP_RESET_COUNTS: begin
        for (int i = 0; i < NUM_WHEELS; i++) enc_count[i] = '0;
      end
      default: ;
    endcase
    total = 0;
    abs_total = 0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      v = longint'($signed(enc_count[i]));
      total += v;
      abs_total += (v < 0) ? -v : v;
    end
    // Signed division truncates toward zero, as the averaging requires.
    total = total / 4;
    abs_total = abs_total >> 2;
    s.duty_fl = wheel_duty[0];
    s.duty_fr = wheel_duty[1];
    s.duty_bl = wheel_duty[2];
    s.duty_br = wheel_duty[3];
    s.drive = drive_state;
    s.count = enc_count[w];
    s.period = enc_period[w];
    s.avg = total[31:0];
    s.avg_abs = abs_total[31:0];
    return s;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_status = m_axis_tdata;
        status_done++;
        if (pending_status.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing pending, expected none, actual %h",
                   $time, m_axis_tdata);
        end else begin
          want_status = pending_status.pop_front();
          check_field("duty_front_left", 32'(want_status.duty_fl),
                      32'(got_status.duty_fl));
          check_field("duty_front_right", 32'(want_status.duty_fr),
                      32'(got_status.duty_fr));
          check_field("duty_back_left", 32'(want_status.duty_bl),
                      32'(got_status.duty_bl));
          check_field("duty_back_right", 32'(want_status.duty_br),
                      32'(got_status.duty_br));
          check_field("drive_bits", 32'(want_status.drive), 32'(got_status.drive));
          check_field("wheel_count", want_status.count, got_status.count);
          check_field("wheel_period", want_status.period, got_status.period);
          check_field("average_count", want_status.avg, got_status.avg);
          check_field("average_abs_count", want_status.avg_abs, got_status.avg_abs);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_status.push_back(apply_command(s_axis_tdata));
        cmds_taken++;
      end
    end
  end

  // Result side: after each transaction, hold tready low for a random number of cycles.
  always @(negedge clk_i) begin
    if (status_done != rx_mark) begin
      rx_mark = status_done;
      rx_hold = quiet ? 0 : $urandom_range(0, MAX_IDLE);
      m_axis_tready <= (rx_hold == 0);
    end else if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= (rx_hold == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // All tasks below start and end at a falling edge.
  task automatic send_cmd(input item_t c);
    int gap;
    int mark;
    gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= to_tdata(c);
    mark = cmds_taken;
    do @(negedge clk_i); while (cmds_taken == mark);
  endtask

  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk_i);
    repeat (PIPE_DEPTH + 2) @(negedge clk_i);
  endtask

  task automatic write_sync_delay(input logic [15:0] value);
    drain_pipeline();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    trim_delay = value;
  endtask

  // Fields that an opcode does not use still carry random content.
  function automatic item_t random_cmd(input logic [2:0] op);
    item_t c;
    c.opcode = op;
    c.wheel = 2'($urandom_range(0, 3));
    c.level_a = 1'($urandom_range(0, 1));
    c.level_b = 1'($urandom_range(0, 1));
    c.time_us = $urandom();
    c.time_ms = $urandom();
    c.direction = 3'($urandom_range(0, 7));
    c.duty = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic encoder_event(input logic [1:0] w, input logic a, input logic b,
                               input logic [31:0] tus);
    item_t c;
    c = random_cmd(OP_ENCODER);
    c.wheel = w;
    c.level_a = a;
    c.level_b = b;
    c.time_us = tus;
    send_cmd(c);
  endtask

  task automatic move_cmd(input logic [2:0] dir, input logic [7:0] duty,
                          input logic [31:0] tms);
    item_t c;
    c = random_cmd(OP_MOVE);
    c.direction = dir;
    c.duty = duty;
    c.time_ms = tms;
    send_cmd(c);
  endtask

  task automatic sync_tick(input logic [31:0] tms);
    item_t c;
    c = random_cmd(OP_SYNC);
    c.time_ms = tms;
    send_cmd(c);
  endtask

  // Count up, hold, count down, interval wrap; leaves the back right wheel fastest.
  task automatic test_encoder_counting();
    encoder_event(2'd0, 1'b1, 1'b0, 32'd1000);
    encoder_event(2'd0, 1'b1, 1'b1, 32'd1500);
    encoder_event(2'd0, 1'b0, 1'b0, 32'hFFFF_FFF0);
    encoder_event(2'd0, 1'b1, 1'b1, 32'h0000_0010);
    encoder_event(2'd1, 1'b1, 1'b0, 32'd800);
    encoder_event(2'd2, 1'b1, 1'b1, 32'hFFFF_FFFF);
    encoder_event(2'd3, 1'b0, 1'b1, 32'd20);
    encoder_event(2'd3, 1'b1, 1'b0, 32'd40);
  endtask

  task automatic test_move_directions();
    move_cmd(DIR_FWD, 8'd0, 32'd0);
    move_cmd(DIR_BACK, 8'd255, 32'd10);
    move_cmd(DIR_LEFT, 8'd1, 32'hFFFF_FFFF);
    move_cmd(DIR_RIGHT, 8'd128, 32'd30);
    move_cmd(DIR_CW, 8'd127, 32'd40);
    move_cmd(DIR_CCW, 8'd254, 32'd50);
    // Unknown directions keep the last drive bits but still load duty and start time.
    move_cmd(DIR_SPARE_6, 8'd77, 32'd60);
    move_cmd(DIR_SPARE_7, 8'd200, 32'd70);
  endtask

  // Trimming at the exact delay, just past it, saturation high and low, and time wrap.
  task automatic test_sync_trimming();
    move_cmd(DIR_FWD, 8'd255, 32'hFFFF_FFC0);
    sync_tick(32'hFFFF_FFC0 + 32'd100);
    sync_tick(32'hFFFF_FFC0 + 32'd101);
    move_cmd(DIR_BACK, 8'd0, 32'd500);
    sync_tick(32'd700);
  endtask

  task automatic test_stop_and_clear();
    send_cmd(random_cmd(OP_STOP));
    send_cmd(random_cmd(OP_RESET_COUNTS));
    send_cmd(random_cmd(OP_SPARE_5));
    send_cmd(random_cmd(OP_SPARE_6));
    send_cmd(random_cmd(OP_SPARE_7));
  endtask

  task automatic test_sync_delay_extremes();
    move_cmd(DIR_CW, 8'd100, 32'd1000);
    write_sync_delay(16'd0);
    sync_tick(32'd1000);
    sync_tick(32'd1001);
    write_sync_delay(16'hFFFF);
    sync_tick(32'd1000 + 32'd65535);
    sync_tick(32'd1000 + 32'd65536);
  endtask

  // Mostly clean quadrature sequences per wheel with moves, timed ticks, stops and count resets, plus noise.
  task automatic test_random_traffic();
    logic [15:0] settings [6];
    int          phase [NUM_WHEELS];
    bit          fwd [NUM_WHEELS];
    logic [31:0] us_now [NUM_WHEELS];
    int          rate [NUM_WHEELS];
    int          jitter;
    logic [31:0] ms_now;
    logic [31:0] start_ms;
    logic [31:0] delta;
    item_t       c;
    int          roll;
    int          w;
    settings = '{16'd0, 16'hFFFF, 16'($urandom()), SYNC_DELAY_RESET, 16'd1,
                 16'($urandom())};
    ms_now = $urandom();
    start_ms = ms_now;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      phase[i] = 0;
      fwd[i] = 1'b1;
      us_now[i] = $urandom();
    end
    for (int p = 0; p < 6; p++) begin
      write_sync_delay(settings[p]);
      jitter = ($urandom_range(0, 2) == 0) ? 0 : 60;
      for (int i = 0; i < NUM_WHEELS; i++) rate[i] = $urandom_range(100, 3000);
      if ($urandom_range(0, 1) == 0) rate[3] = rate[0];
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
        // Let the block run dry now and then while traffic is in full flow.
        if ((p == 0 && k == PHASE_ITEMS / 2) || $urandom_range(0, 99) == 0) drain_pipeline();
        roll = $urandom_range(0, 99);
        c = random_cmd(3'($urandom_range(0, 7)));
        if (roll < 50) begin
          w = $urandom_range(0, NUM_WHEELS - 1);
          if ($urandom_range(0, 19) == 0) fwd[w] = !fwd[w];
          phase[w] = (phase[w] + (fwd[w] ? 1 : 3)) % 4;
          if ($urandom_range(0, 49) == 0) us_now[w] = $urandom();
          else us_now[w] = us_now[w] + rate[w] + $urandom_range(0, jitter);
          c.opcode = OP_ENCODER;
          c.wheel = 2'(w);
          c.level_a = (phase[w] == 1 || phase[w] == 2);
          c.level_b = (phase[w] >= 2);
          c.time_us = us_now[w];
        end else if (roll < 72) begin
          if ($urandom_range(0, 9) < 4) delta = {16'd0, trim_delay} + $urandom_range(0, 2) - 1;
          else delta = $urandom_range(0, 2 * trim_delay + 20);
          c.opcode = OP_SYNC;
          c.time_ms = start_ms + delta;
        end else if (roll < 80) begin
          if ($urandom_range(0, 19) == 0) ms_now = $urandom();
          else ms_now = ms_now + $urandom_range(0, 2000);
          start_ms = ms_now;
          c.opcode = OP_MOVE;
          c.time_ms = ms_now;
          c.direction = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                    : 3'($urandom_range(0, 5));
        end else if (roll < 83) begin
          c.opcode = OP_STOP;
        end else if (roll < 85) begin
          c.opcode = OP_RESET_COUNTS;
        end
        send_cmd(c);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_encoder_counting();
    test_move_directions();
    test_sync_trimming();
    test_stop_and_clear();
    test_sync_delay_extremes();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk_i);
    repeat (PIPE_DEPTH + 4) @(negedge clk_i);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
